[design/sfla_pkg.sv]
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants for the frame luma average block
// Widths, register indexes, reset values and the command passed from the
// pixel front end to the division back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sfla_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int POS_W         = $clog2(MAX_DIMENSION);
   localparam int DIM_W         = 13;

   localparam int WEIGHT_W   = 16;
   localparam int CHAN_W     = 8;
   localparam int PROD_W     = WEIGHT_W + CHAN_W;
   localparam int LUMA_W     = PROD_W + 2;
   localparam int SPACING_W  = 7;
   localparam int INTERVAL_W = 8;
   localparam int SUM_W      = 48;
   localparam int CNT_W      = 25;
   localparam int FRAMES_W   = 24;
   localparam int AVG_W      = 24;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RED_WEIGHT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_WEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_WEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_SPACING = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_INTERVAL = 3'd6;

   localparam logic [WEIGHT_W-1:0]   RESET_RED_WEIGHT     = 16'd19595;
   localparam logic [WEIGHT_W-1:0]   RESET_GREEN_WEIGHT   = 16'd38470;
   localparam logic [WEIGHT_W-1:0]   RESET_BLUE_WEIGHT    = 16'd7471;
   localparam logic [DIM_W-1:0]      RESET_FRAME_WIDTH    = 13'd640;
   localparam logic [DIM_W-1:0]      RESET_FRAME_HEIGHT   = 13'd480;
   localparam logic [SPACING_W-1:0]  RESET_SAMPLE_SPACING = 7'd1;
   localparam logic [INTERVAL_W-1:0] RESET_FRAME_INTERVAL = 8'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Quotient bits produced by the serial divider, one per cycle.
   localparam int DIV_STEPS  = SUM_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   typedef logic [0:0] cmd_kind_type;
   localparam cmd_kind_type CMD_FRAME = 1'b0;
   localparam cmd_kind_type CMD_VIDEO = 1'b1;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [SUM_W-1:0]   sum;
      logic [CNT_W-1:0]   count;
   } stats_cmd_type;

endpackage

`default_nettype wire

[design/sfla_queue.sv]
// ----------------------------------------------------------------------------
// sfla_queue: short command queue between front end and back end
// Holds frame-end and end-of-video commands so the pixel path waits on the
// divider only when the queue would fill.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  sfla_pkg::stats_cmd_type        push_cmd,
   input  logic                           pop,
   output sfla_pkg::stats_cmd_type        head_cmd,
   output logic                           empty,
   output logic [sfla_pkg::QUEUE_CNT_W-1:0] count
);
   import sfla_pkg::*;

   stats_cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic                     do_pop;

   assign do_pop   = pop && (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[design/sfla_front.sv]
// ----------------------------------------------------------------------------
// sfla_front: pixel front end
// Holds the configuration registers, tracks raster position and sampling
// phase, computes luma in a short pipeline and accumulates the frame sum.
// Measured frame ends and end of video go to the back end as commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sfla_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfla_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,
   input  logic [3*sfla_pkg::CHAN_W-1:0]     req_tdata,
   input  logic [sfla_pkg::QUEUE_CNT_W-1:0]  queue_count,
   output logic                              push,
   output sfla_pkg::stats_cmd_type           push_cmd
);
   import sfla_pkg::*;

   typedef struct packed {
      logic is_video;
      logic sample;
      logic frame_end;
      logic measured;
   } pixel_flags_type;

   localparam int RESYNC_W = $clog2(POS_W + 1);

   // Configuration registers
   logic [WEIGHT_W-1:0]   red_weight_ff;
   logic [WEIGHT_W-1:0]   green_weight_ff;
   logic [WEIGHT_W-1:0]   blue_weight_ff;
   logic [DIM_W-1:0]      frame_width_ff;
   logic [DIM_W-1:0]      frame_height_ff;
   logic [SPACING_W-1:0]  sample_spacing_ff;
   logic [INTERVAL_W-1:0] frame_interval_ff;

   // Raster position state
   logic [POS_W-1:0]      column_ff, column_in;
   logic [POS_W-1:0]      row_ff, row_in;
   logic [INTERVAL_W-1:0] phase_ff, phase_in;
   logic [SPACING_W-1:0]  col_res_ff, col_res_in;
   logic [SPACING_W-1:0]  row_res_ff, row_res_in;

   // Residue recompute after a spacing change
   logic                  resync_ff;
   logic [RESYNC_W-1:0]   resync_step_ff;
   logic [POS_W-1:0]      col_shift_ff;
   logic [POS_W-1:0]      row_shift_ff;

   // Luma pipeline
   logic                  s1_valid_ff;
   pixel_flags_type       s1_flags_ff;
   logic [PROD_W-1:0]     prod_red_ff;
   logic [PROD_W-1:0]     prod_green_ff;
   logic [PROD_W-1:0]     prod_blue_ff;
   logic                  s2_valid_ff;
   pixel_flags_type       s2_flags_ff;
   logic [LUMA_W-1:0]     luma_ff;

   // Frame accumulator
   logic [SUM_W-1:0]      frame_sum_ff, frame_sum_in;
   logic [CNT_W-1:0]      frame_count_ff, frame_count_in;

   logic [DIM_W-1:0]      width_eff;
   logic [DIM_W-1:0]      height_eff;
   logic [SPACING_W-1:0]  spacing_eff;
   logic [INTERVAL_W-1:0] interval_eff;
   logic                  measured;
   logic                  line_end;
   logic                  frame_end;
   logic                  accept;
   logic                  is_video;
   logic                  sample;
   logic [QUEUE_CNT_W:0]  in_flight;
   logic [SPACING_W:0]    col_trial;
   logic [SPACING_W:0]    row_trial;
   logic [SPACING_W-1:0]  col_res_inc;
   logic [SPACING_W-1:0]  row_res_inc;
   logic [SUM_W:0]        sum_wide;
   logic [SUM_W-1:0]      sum_next;
   logic [CNT_W-1:0]      count_next;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = DIM_W'(1);
      end else if (frame_width_ff > DIM_W'(MAX_DIMENSION)) begin
         width_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         height_eff = DIM_W'(1);
      end else if (frame_height_ff > DIM_W'(MAX_DIMENSION)) begin
         height_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         height_eff = frame_height_ff;
      end
   end

   assign spacing_eff  = (sample_spacing_ff == '0) ? SPACING_W'(1) : sample_spacing_ff;
   assign interval_eff = (frame_interval_ff == '0) ? INTERVAL_W'(1) : frame_interval_ff;

   assign measured  = ({1'b0, phase_ff} + (INTERVAL_W + 1)'(1)) >= {1'b0, interval_eff};
   assign line_end  = ({1'b0, column_ff} + DIM_W'(1)) >= width_eff;
   assign frame_end = line_end && (({1'b0, row_ff} + DIM_W'(1)) >= height_eff);
   assign is_video  = req_tuser;
   assign sample    = measured && (col_res_ff == '0) && (row_res_ff == '0);

   // Leave room in the queue for every beat already in the pipeline.
   assign in_flight  = (QUEUE_CNT_W + 1)'(queue_count) + (QUEUE_CNT_W + 1)'(s1_valid_ff)
                     + (QUEUE_CNT_W + 1)'(s2_valid_ff);
   assign req_tready = !resync_ff && (in_flight < (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   assign col_res_inc = col_res_ff + 1'b1;
   assign row_res_inc = row_res_ff + 1'b1;
   assign col_trial   = {col_res_ff, col_shift_ff[POS_W-1]};
   assign row_trial   = {row_res_ff, row_shift_ff[POS_W-1]};

   always_comb begin
      column_in  = column_ff;
      row_in     = row_ff;
      phase_in   = phase_ff;
      col_res_in = col_res_ff;
      row_res_in = row_res_ff;
      if (resync_ff) begin
         // Restoring remainder, one position bit per cycle, MSB first.
         if (col_trial >= {1'b0, spacing_eff}) begin
            col_res_in = SPACING_W'(col_trial - {1'b0, spacing_eff});
         end else begin
            col_res_in = SPACING_W'(col_trial);
         end
         if (row_trial >= {1'b0, spacing_eff}) begin
            row_res_in = SPACING_W'(row_trial - {1'b0, spacing_eff});
         end else begin
            row_res_in = SPACING_W'(row_trial);
         end
      end else if (accept) begin
         if (is_video) begin
            column_in  = '0;
            row_in     = '0;
            phase_in   = '0;
            col_res_in = '0;
            row_res_in = '0;
         end else if (!line_end) begin
            column_in  = column_ff + 1'b1;
            col_res_in = (col_res_inc >= spacing_eff) ? '0 : col_res_inc;
         end else begin
            column_in  = '0;
            col_res_in = '0;
            if (!frame_end) begin
               row_in     = row_ff + 1'b1;
               row_res_in = (row_res_inc >= spacing_eff) ? '0 : row_res_inc;
            end else begin
               row_in     = '0;
               row_res_in = '0;
               phase_in   = measured ? '0 : phase_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_weight_ff     <= RESET_RED_WEIGHT;
         green_weight_ff   <= RESET_GREEN_WEIGHT;
         blue_weight_ff    <= RESET_BLUE_WEIGHT;
         frame_width_ff    <= RESET_FRAME_WIDTH;
         frame_height_ff   <= RESET_FRAME_HEIGHT;
         sample_spacing_ff <= RESET_SAMPLE_SPACING;
         frame_interval_ff <= RESET_FRAME_INTERVAL;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RED_WEIGHT:     red_weight_ff     <= csr_wdata;
            CSR_GREEN_WEIGHT:   green_weight_ff   <= csr_wdata;
            CSR_BLUE_WEIGHT:    blue_weight_ff    <= csr_wdata;
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata[DIM_W-1:0];
            CSR_SAMPLE_SPACING: sample_spacing_ff <= csr_wdata[SPACING_W-1:0];
            CSR_FRAME_INTERVAL: frame_interval_ff <= csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         row_ff         <= '0;
         phase_ff       <= '0;
         col_res_ff     <= '0;
         row_res_ff     <= '0;
         resync_ff      <= 1'b0;
         resync_step_ff <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         phase_ff  <= phase_in;
         if (csr_we && (csr_index == CSR_SAMPLE_SPACING)) begin
            // Residues of the current position must follow the new spacing.
            resync_ff      <= 1'b1;
            resync_step_ff <= '0;
            col_res_ff     <= '0;
            row_res_ff     <= '0;
         end else begin
            col_res_ff <= col_res_in;
            row_res_ff <= row_res_in;
            if (resync_ff) begin
               resync_step_ff <= resync_step_ff + 1'b1;
               if (resync_step_ff == RESYNC_W'(POS_W - 1)) begin
                  resync_ff <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (csr_we && (csr_index == CSR_SAMPLE_SPACING)) begin
         col_shift_ff <= column_ff;
         row_shift_ff <= row_ff;
      end else if (resync_ff) begin
         col_shift_ff <= {col_shift_ff[POS_W-2:0], 1'b0};
         row_shift_ff <= {row_shift_ff[POS_W-2:0], 1'b0};
      end
   end

   // Stage 1: weighted channels. Stage 2: luma.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_flags_ff.is_video  <= is_video;
      s1_flags_ff.sample    <= sample;
      s1_flags_ff.frame_end <= frame_end;
      s1_flags_ff.measured  <= measured;
      prod_red_ff   <= red_weight_ff * req_tdata[CHAN_W-1:0];
      prod_green_ff <= green_weight_ff * req_tdata[2*CHAN_W-1:CHAN_W];
      prod_blue_ff  <= blue_weight_ff * req_tdata[3*CHAN_W-1:2*CHAN_W];
      s2_flags_ff   <= s1_flags_ff;
      luma_ff       <= LUMA_W'(prod_red_ff) + LUMA_W'(prod_green_ff)
                     + LUMA_W'(prod_blue_ff);
   end

   // Stage 3: saturating frame accumulation.
   always_comb begin
      sum_wide   = {1'b0, frame_sum_ff} + (SUM_W + 1)'(luma_ff);
      sum_next   = frame_sum_ff;
      count_next = frame_count_ff;
      if (s2_flags_ff.sample) begin
         sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         if (frame_count_ff != {CNT_W{1'b1}}) begin
            count_next = frame_count_ff + 1'b1;
         end
      end
      frame_sum_in   = frame_sum_ff;
      frame_count_in = frame_count_ff;
      if (s2_valid_ff) begin
         if (s2_flags_ff.is_video || s2_flags_ff.frame_end) begin
            frame_sum_in   = '0;
            frame_count_in = '0;
         end else begin
            frame_sum_in   = sum_next;
            frame_count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_sum_ff   <= '0;
         frame_count_ff <= '0;
      end else begin
         frame_sum_ff   <= frame_sum_in;
         frame_count_ff <= frame_count_in;
      end
   end

   assign push = s2_valid_ff && (s2_flags_ff.is_video
                                 || (s2_flags_ff.frame_end && s2_flags_ff.measured));
   assign push_cmd.kind  = s2_flags_ff.is_video ? CMD_VIDEO : CMD_FRAME;
   assign push_cmd.sum   = sum_next;
   assign push_cmd.count = count_next;

endmodule

`default_nettype wire

[design/sfla_back.sv]
// ----------------------------------------------------------------------------
// sfla_back: division back end
// Takes commands from the queue, divides with a bit-serial restoring divider,
// keeps the video statistics and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           queue_empty,
   input  sfla_pkg::stats_cmd_type        head_cmd,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_tuser,
   output logic [sfla_pkg::AVG_W-1:0]     rsp_tdata
);
   import sfla_pkg::*;

   localparam logic [1:0] BACK_IDLE   = 2'd0;
   localparam logic [1:0] BACK_DIVIDE = 2'd1;
   localparam logic [1:0] BACK_EMIT   = 2'd2;

   logic [1:0]            state_ff;
   cmd_kind_type          kind_ff;
   logic [SUM_W-1:0]      quo_ff;
   logic [CNT_W:0]        rem_ff;
   logic [CNT_W-1:0]      den_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [SUM_W-1:0]      video_sum_ff;
   logic [FRAMES_W-1:0]   frames_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_user_ff;
   logic [AVG_W-1:0]      rsp_data_ff;

   logic [CNT_W:0]        trial;
   logic                  fits;
   logic [AVG_W-1:0]      average;
   logic [SUM_W:0]        video_wide;
   logic                  out_free;
   logic                  emit;

   assign pop      = (state_ff == BACK_IDLE) && !queue_empty;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = (state_ff == BACK_EMIT) && out_free;

   // Remainder stays below the divisor, so one extra bit holds the shifted value.
   assign trial = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      if (den_ff == '0) begin
         average = '0;
      end else if (quo_ff[SUM_W-1:AVG_W] != '0) begin
         average = {AVG_W{1'b1}};
      end else begin
         average = quo_ff[AVG_W-1:0];
      end
   end

   assign video_wide = {1'b0, video_sum_ff} + (SUM_W + 1)'(average);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         step_ff      <= '0;
         video_sum_ff <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !emit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            BACK_IDLE: begin
               if (!queue_empty) begin
                  step_ff  <= '0;
                  state_ff <= BACK_DIVIDE;
               end
            end
            BACK_DIVIDE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
                  state_ff <= BACK_EMIT;
               end
            end
            BACK_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= BACK_IDLE;
                  if (kind_ff == CMD_VIDEO) begin
                     video_sum_ff <= '0;
                     frames_ff    <= '0;
                  end else begin
                     video_sum_ff <= video_wide[SUM_W] ? {SUM_W{1'b1}}
                                                       : video_wide[SUM_W-1:0];
                     if (frames_ff != {FRAMES_W{1'b1}}) begin
                        frames_ff <= frames_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= BACK_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= head_cmd.kind;
         rem_ff  <= '0;
         if (head_cmd.kind == CMD_VIDEO) begin
            quo_ff <= video_sum_ff;
            den_ff <= CNT_W'(frames_ff);
         end else begin
            quo_ff <= head_cmd.sum;
            den_ff <= head_cmd.count;
         end
      end else if (state_ff == BACK_DIVIDE) begin
         rem_ff <= fits ? (trial - {1'b0, den_ff}) : trial;
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_user_ff <= (kind_ff == CMD_VIDEO);
         rsp_data_ff <= average;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[design/subsampled_frame_luma_average.sv]
// ----------------------------------------------------------------------------
// subsampled_frame_luma_average: frame luma exposure statistics
// Averages weighted luma over subsampled pixels of every n-th frame and
// reports per-frame and whole-video averages in unsigned Q8.16.
// ----------------------------------------------------------------------------
//
//  Port group | Direction | Beat contents
//  -----------+-----------+------------------------------------------------
//  req_       | in        | one pixel or an end-of-video marker
//  rsp_       | out       | one frame average or the video average
//  csr_       | in        | register write, no read-back
//
// Pixels are taken one per cycle while req_tready is high; the luma pipeline
// is three stages deep. Each measured frame end and each end-of-video beat
// passes through the serial divider (48 quotient bits plus load and output);
// a four-entry queue lets those overlap the next frame, and apart from a
// sample_spacing write, req_tready drops only when the queued commands plus
// the beats still in the luma pipeline would fill it. Writing sample_spacing
// holds req_tready low while the position residues are recomputed. Reset is
// synchronous, clears all statistics and restores the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module subsampled_frame_luma_average (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sfla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfla_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,   // kind
   input  logic [3*sfla_pkg::CHAN_W-1:0]    req_tdata,   // red, green, blue
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic                             rsp_tuser,   // is_video_average
   output logic [sfla_pkg::AVG_W-1:0]       rsp_tdata    // average_luma
);
   import sfla_pkg::*;

   logic                     push;
   stats_cmd_type            push_cmd;
   logic                     pop;
   stats_cmd_type            head_cmd;
   logic                     queue_empty;
   logic [QUEUE_CNT_W-1:0]   queue_count;

   sfla_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .queue_count (queue_count),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   sfla_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .count    (queue_count)
   );

   sfla_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire
